### hdl/periodic_voltage_monitor_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the periodic voltage monitor
// Shared wrappers so every checked module reports in the same way.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_VOLTAGE_MONITOR_UNIT_MACROS_SVH
`define PERIODIC_VOLTAGE_MONITOR_UNIT_MACROS_SVH

// Checked on every rising edge while out of reset.
`define PVM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define PVM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hdl/pvm_pkg.sv
// ----------------------------------------------------------------------------
// pvm_pkg
// Types and constants shared by the periodic voltage monitor modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pvm_pkg;

  localparam int unsigned IntervalW  = 8;
  localparam int unsigned SampleW    = 12;
  localparam int unsigned TotalW     = 20;
  localparam int unsigned ReportW    = 16;
  localparam int unsigned DivSteps   = TotalW;
  localparam int unsigned DivCntW    = $clog2(DivSteps);

  localparam logic [IntervalW-1:0] IntervalReset = 8'd6;
  localparam logic [SampleW-1:0]   LowVoltageMv  = 12'd1200;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_START = 2'd1,
    PH_SEND  = 2'd2,
    PH_SENT  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ACT_SLEEP  = 2'd0,
    ACT_WAKEUP = 2'd1,
    ACT_POLL   = 2'd2,
    ACT_ACK    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_DIV,
    CTL_PUSH
  } ctl_state_e;

  // Control from the sequencer to the datapath registers.
  typedef struct packed {
    logic in_ready;
    logic div_start;
    logic load_event;
    logic load_report;
  } ctl_t;

endpackage

### hdl/pvm_in_if.sv
// ----------------------------------------------------------------------------
// pvm_in_if
// Event channel: action, ADC sample and acknowledge result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pvm_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [pvm_pkg::SampleW-1:0]  sample_mv;
  logic                         send_ok;

  modport source (output valid, output action, output sample_mv, output send_ok,
                  input ready);
  modport sink   (input valid, input action, input sample_mv, input send_ok,
                  output ready);
endinterface

### hdl/pvm_out_if.sv
// ----------------------------------------------------------------------------
// pvm_out_if
// Result channel: monitor status after each event and the averaged report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pvm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         adc_power;
  logic                         report_valid;
  logic [pvm_pkg::ReportW-1:0]  report_value;
  logic                         alarm;
  logic [1:0]                   phase;

  modport source (output valid, output adc_power, output report_valid,
                  output report_value, output alarm, output phase, input ready);
  modport sink   (input valid, input adc_power, input report_valid,
                  input report_value, input alarm, input phase, output ready);
endinterface

### hdl/pvm_cfg_if.sv
// ----------------------------------------------------------------------------
// pvm_cfg_if
// Configuration write channel for the report interval register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pvm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pvm_pkg::IntervalW-1:0]  report_interval;

  modport source (output valid, output report_interval, input ready);
  modport sink   (input valid, input report_interval, output ready);
endinterface

### hdl/pvm_div.sv
// ----------------------------------------------------------------------------
// pvm_div
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "periodic_voltage_monitor_unit_macros.svh"

module pvm_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [pvm_pkg::TotalW-1:0]      dividend_i,
  input  logic [pvm_pkg::IntervalW-1:0]   divisor_i,
  output logic                            done_o,
  output logic [pvm_pkg::TotalW-1:0]      quotient_o
);

  logic                            busy_q, busy_d;
  logic [pvm_pkg::DivCntW-1:0]     cnt_q, cnt_d;
  logic [pvm_pkg::TotalW-1:0]      dq_q, dq_d;
  logic [pvm_pkg::IntervalW:0]     rem_q, rem_d;
  logic [pvm_pkg::IntervalW-1:0]   dsr_q, dsr_d;
  logic [pvm_pkg::IntervalW:0]     rem_shift;
  logic                            fits;

  // The dividend shifts out of the top of dq while quotient bits enter at
  // the bottom. A zero divisor always fits, which yields an all-ones quotient.
  assign rem_shift = {rem_q[pvm_pkg::IntervalW-1:0], dq_q[pvm_pkg::TotalW-1]};
  assign fits      = (rem_shift >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = pvm_pkg::DivCntW'(pvm_pkg::DivSteps - 1);
      dq_d   = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      dq_d  = {dq_q[pvm_pkg::TotalW-2:0], fits};
      rem_d = fits ? (rem_shift - {1'b0, dsr_q}) : rem_shift;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = dq_q;

  `PVM_ASSERT(a_start_when_free, start_i |-> !busy_q, "divider started while busy")
  `PVM_ASSERT(a_count_range, busy_q |-> (cnt_q <= pvm_pkg::DivCntW'(pvm_pkg::DivSteps - 1)),
              "divider step count out of range")
  `PVM_ASSERT(a_done_ends_busy, done_o |=> !busy_q, "divider still busy after done")

endmodule

### hdl/periodic_voltage_monitor_unit.sv
// ----------------------------------------------------------------------------
// periodic_voltage_monitor_unit
// Sensor-node monitor: sampling cadence, voltage sum, report and alarm.
//
//  Channel  Dir  Payload                                            Size
//  in_i     in   action, sample_mv, send_ok                         15 b
//  out_o    out  adc_power, report_valid, report_value, alarm, phase 21 b
//  cfg_i    in   report_interval                                    8 b
//
// Sleep, wakeup and acknowledge events load their status into the output register.
// A poll in the send phase starts the bit-serial divider, and the quotient
// then moves into the output register.
// Reset clears all monitor state and sets the report interval to 6.
// A result waiting on the output blocks new events, and none are taken while
// a report is divided or waits to be pushed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "periodic_voltage_monitor_unit_macros.svh"

module periodic_voltage_monitor_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  pvm_in_if.sink    in_i,
  pvm_out_if.source out_o,
  pvm_cfg_if.sink   cfg_i
);

  pvm_pkg::ctl_state_e              state_q, state_d;
  pvm_pkg::ctl_t                    ctl;
  pvm_pkg::phase_e                  phase_q, phase_d;
  logic [pvm_pkg::IntervalW-1:0]    interval_q;
  logic [pvm_pkg::IntervalW-1:0]    sample_cd_q, sample_cd_d;
  logic [pvm_pkg::IntervalW-1:0]    notify_cd_q, notify_cd_d, notify_dec;
  logic [pvm_pkg::SampleW-1:0]      last_mv_q, last_mv_d;
  logic [pvm_pkg::TotalW-1:0]       total_q, total_d;
  logic                             alarm_q, alarm_d;
  logic                             adc_q, adc_d;
  logic                             in_fire, is_poll_send, out_free;
  logic                             div_done;
  logic [pvm_pkg::TotalW-1:0]       quotient;

  logic                             out_valid_q;
  logic                             out_adc_q, out_rv_q, out_alarm_q;
  logic [pvm_pkg::ReportW-1:0]      out_value_q;
  logic [1:0]                       out_phase_q;

  assign out_free     = !out_valid_q || out_o.ready;
  assign in_fire      = in_i.valid && ctl.in_ready;
  assign is_poll_send = (pvm_pkg::action_e'(in_i.action) == pvm_pkg::ACT_POLL) &&
                        (phase_q == pvm_pkg::PH_SEND);

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pvm_pkg::CTL_IDLE: begin
        if (in_fire && is_poll_send) begin
          state_d = pvm_pkg::CTL_DIV;
        end
      end
      pvm_pkg::CTL_DIV: begin
        if (div_done) begin
          state_d = pvm_pkg::CTL_PUSH;
        end
      end
      pvm_pkg::CTL_PUSH: begin
        if (out_free) begin
          state_d = pvm_pkg::CTL_IDLE;
        end
      end
      default: state_d = pvm_pkg::CTL_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ctl = '0;
    unique case (state_q)
      pvm_pkg::CTL_IDLE: begin
        ctl.in_ready   = out_free;
        ctl.div_start  = in_fire && is_poll_send;
        ctl.load_event = in_fire && !is_poll_send;
      end
      pvm_pkg::CTL_PUSH: begin
        ctl.load_report = out_free;
      end
      default: ctl = '0;
    endcase
  end

  // Monitor state update for one accepted event.
  assign notify_dec = (notify_cd_q != '0) ? (notify_cd_q - 1'b1) : notify_cd_q;

  always_comb begin
    phase_d     = phase_q;
    sample_cd_d = sample_cd_q;
    notify_cd_d = notify_cd_q;
    last_mv_d   = last_mv_q;
    total_d     = total_q;
    alarm_d     = alarm_q;
    adc_d       = adc_q;
    unique case (pvm_pkg::action_e'(in_i.action))
      pvm_pkg::ACT_SLEEP: begin
        if (phase_q == pvm_pkg::PH_WAIT && sample_cd_q == '0) begin
          sample_cd_d = interval_q;
          adc_d       = 1'b1;
          phase_d     = pvm_pkg::PH_START;
        end else if (sample_cd_q != '0) begin
          sample_cd_d = sample_cd_q - 1'b1;
        end
      end
      pvm_pkg::ACT_WAKEUP: begin
        if (phase_q == pvm_pkg::PH_START) begin
          last_mv_d = in_i.sample_mv;
          total_d   = total_q + pvm_pkg::TotalW'(in_i.sample_mv);
          adc_d     = 1'b0;
          if (notify_dec == '0) begin
            notify_cd_d = interval_q;
            phase_d     = pvm_pkg::PH_SEND;
          end else begin
            notify_cd_d = notify_dec;
            phase_d     = pvm_pkg::PH_WAIT;
          end
        end
        // Every wakeup refreshes the alarm from the latest stored voltage.
        alarm_d = (last_mv_d < pvm_pkg::LowVoltageMv);
      end
      pvm_pkg::ACT_POLL: begin
        if (phase_q == pvm_pkg::PH_SEND) begin
          phase_d = pvm_pkg::PH_SENT;
        end
      end
      pvm_pkg::ACT_ACK: begin
        if (phase_q == pvm_pkg::PH_SENT) begin
          if (in_i.send_ok) begin
            total_d = '0;
            phase_d = pvm_pkg::PH_WAIT;
          end else begin
            phase_d = pvm_pkg::PH_SEND;
          end
        end
      end
      default: phase_d = phase_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pvm_pkg::CTL_IDLE;
      phase_q     <= pvm_pkg::PH_WAIT;
      interval_q  <= pvm_pkg::IntervalReset;
      sample_cd_q <= '0;
      notify_cd_q <= '0;
      last_mv_q   <= '0;
      total_q     <= '0;
      alarm_q     <= 1'b0;
      adc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        interval_q <= cfg_i.report_interval;
      end
      if (in_fire) begin
        phase_q     <= phase_d;
        sample_cd_q <= sample_cd_d;
        notify_cd_q <= notify_cd_d;
        last_mv_q   <= last_mv_d;
        total_q     <= total_d;
        alarm_q     <= alarm_d;
        adc_q       <= adc_d;
      end
      if (ctl.load_event || ctl.load_report) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload; phase and flags already hold the post-event values when
  // the report is pushed, since no event is taken while the divider runs.
  always_ff @(posedge clk_i) begin
    if (ctl.load_event) begin
      out_adc_q   <= adc_d;
      out_rv_q    <= 1'b0;
      out_value_q <= '0;
      out_alarm_q <= alarm_d;
      out_phase_q <= phase_d;
    end else if (ctl.load_report) begin
      out_adc_q   <= adc_q;
      out_rv_q    <= 1'b1;
      out_value_q <= quotient[pvm_pkg::ReportW-1:0];
      out_alarm_q <= alarm_q;
      out_phase_q <= phase_q;
    end
  end

  pvm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.div_start),
    .dividend_i (total_q),
    .divisor_i  (interval_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign in_i.ready         = ctl.in_ready;
  assign cfg_i.ready        = 1'b1;
  assign out_o.valid        = out_valid_q;
  assign out_o.adc_power    = out_adc_q;
  assign out_o.report_valid = out_rv_q;
  assign out_o.report_value = out_value_q;
  assign out_o.alarm        = out_alarm_q;
  assign out_o.phase        = out_phase_q;

  `PVM_ASSERT(a_accept_idle, in_fire |-> (state_q == pvm_pkg::CTL_IDLE),
              "event accepted while a report is in progress")
  `PVM_ASSERT(a_div_phase, (state_q == pvm_pkg::CTL_DIV) |-> (phase_q == pvm_pkg::PH_SENT),
              "divider running outside the sent phase")
  `PVM_ASSERT(a_done_in_div, div_done |-> (state_q == pvm_pkg::CTL_DIV),
              "divider finished outside the divide state")
  `PVM_ASSERT(a_start_enters_div, ctl.div_start |=> (state_q == pvm_pkg::CTL_DIV),
              "divider start did not enter the divide state")

endmodule
